// ----- hw/rtl/sv39ptm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptm_pkg
// Shared constants, codes and types for the Sv39 page table map/lookup core.
// ----------------------------------------------------------------------------
package sv39ptm_pkg;

    localparam int TABLE_FRAMES      = 64;
    localparam int ENTRIES_PER_FRAME = 512;
    localparam int MAX_RUN           = 1024;

    localparam int IDX_W       = $clog2(ENTRIES_PER_FRAME);
    localparam int FRAME_W     = $clog2(TABLE_FRAMES);
    localparam int ADDR_W      = FRAME_W + IDX_W;
    localparam int STORE_DEPTH = TABLE_FRAMES * ENTRIES_PER_FRAME;
    localparam int NFF_W       = $clog2(TABLE_FRAMES + 1);
    localparam int RUN_W       = $clog2(MAX_RUN + 1);

    localparam int VPN_W  = 27;
    localparam int PPN_W  = 44;
    localparam int PERM_W = 8;
    localparam int PC_W   = 11;
    localparam int ST_W   = 2;
    localparam int PTE_W  = 64;
    localparam int CMP_W  = (RUN_W > PC_W) ? RUN_W : PC_W;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_MAP    = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFRAME  = 2'd1;
    localparam logic [ST_W-1:0] ST_REMAP    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] LVL_LEAF = 2'd0;
    localparam logic [1:0] LVL_MID  = 2'd1;
    localparam logic [1:0] LVL_ROOT = 2'd2;

    // register index, taken from paddr[3]
    localparam logic REG_TABLE_BASE = 1'b0;

    typedef struct packed {
        logic              action;
        logic [VPN_W-1:0]  vpn;
        logic [PPN_W-1:0]  ppn;
        logic [PERM_W-1:0] perm;
        logic [PC_W-1:0]   page_count;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [PTE_W-1:0] entry;
    } rsp_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PTE_W-1:0]  wdata;
    } mem_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sv39ptm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptm_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module sv39ptm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sv39ptm_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptm_cfg
// APB register file: table base physical page number.
// ----------------------------------------------------------------------------
module sv39ptm_cfg
    import sv39ptm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [PPN_W-1:0]   table_base
);

    logic [PPN_W-1:0] base_reg;
    logic [PPN_W-1:0] base_next;
    logic             wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[3] == REG_TABLE_BASE);

    always_comb
    begin
        base_next = base_reg;
        if (wr_hit)
        begin
            base_next = pwdata[PPN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            REG_TABLE_BASE: prdata = {{(PDATA_W-PPN_W){1'b0}}, base_reg};
            default:        prdata = '0;
        endcase
    end

    assign table_base = base_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/sv39ptm_walk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptm_walk
// Table walk sequencer: store clearing, lookup, map with frame allocation.
// ----------------------------------------------------------------------------
module sv39ptm_walk
    import sv39ptm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [PPN_W-1:0] table_base,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire req_t             req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output rsp_t                  rsp,
    output mem_req_t              mem_req,
    input  wire logic [PTE_W-1:0] mem_rdata
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_REQ   = 7'b0000100,
        S_CHK   = 7'b0001000,
        S_SWEEP = 7'b0010000,
        S_LINK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t              state_reg,  state_next;
    logic [ADDR_W-1:0]   clr_reg,    clr_next;
    logic [IDX_W-1:0]    sweep_reg,  sweep_next;
    logic                map_reg,    map_next;
    logic [VPN_W-1:0]    vpn_reg,    vpn_next;
    logic [PPN_W-1:0]    ppn_reg,    ppn_next;
    logic [PERM_W-1:0]   perm_reg,   perm_next;
    logic [RUN_W-1:0]    cnt_reg,    cnt_next;
    logic [1:0]          level_reg,  level_next;
    logic [FRAME_W-1:0]  frame_reg,  frame_next;
    logic [NFF_W-1:0]    nff_reg,    nff_next;
    logic [ST_W-1:0]     status_reg, status_next;
    logic [PTE_W-1:0]    entry_reg,  entry_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg,    rsp_next;

    logic [IDX_W-1:0]    idx;
    logic [ADDR_W-1:0]   slot_addr;
    logic [PPN_W-1:0]    e_off;
    logic                e_valid;
    logic                e_inside;
    logic [PTE_W-1:0]    leaf;
    logic [PTE_W-1:0]    link_pte;
    logic [CMP_W-1:0]    pc_ext;
    logic [RUN_W-1:0]    run_len;
    logic                frames_out;

    always_comb
    begin
        case (level_reg)
            LVL_ROOT: idx = vpn_reg[3*IDX_W-1:2*IDX_W];
            LVL_MID:  idx = vpn_reg[2*IDX_W-1:IDX_W];
            default:  idx = vpn_reg[IDX_W-1:0];
        endcase
    end

    assign slot_addr  = {frame_reg, idx};
    assign e_valid    = mem_rdata[0];
    assign e_off      = mem_rdata[PPN_W+9:10] - table_base;
    assign e_inside   = (e_off < PPN_W'(TABLE_FRAMES));
    assign leaf       = {{(PTE_W-PPN_W-10){1'b0}}, ppn_reg, 2'b00, perm_reg | 8'h01};
    assign link_pte   = {{(PTE_W-PPN_W-10){1'b0}}, table_base + PPN_W'(nff_reg), 10'd1};
    assign pc_ext     = CMP_W'(req.page_count);
    assign run_len    = (pc_ext > CMP_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : RUN_W'(pc_ext);
    assign frames_out = (nff_reg >= NFF_W'(TABLE_FRAMES));

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        sweep_next     = sweep_reg;
        map_next       = map_reg;
        vpn_next       = vpn_reg;
        ppn_next       = ppn_reg;
        perm_next      = perm_reg;
        cnt_next       = cnt_reg;
        level_next     = level_reg;
        frame_next     = frame_reg;
        nff_next       = nff_reg;
        status_next    = status_reg;
        entry_next     = entry_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_req        = '{en: 1'b0, we: 1'b0, addr: slot_addr, wdata: '0};

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_req = '{en: 1'b1, we: 1'b1, addr: clr_reg, wdata: '0};
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    map_next    = (req.action == ACT_MAP);
                    vpn_next    = req.vpn;
                    ppn_next    = req.ppn;
                    perm_next   = req.perm;
                    cnt_next    = run_len;
                    level_next  = LVL_ROOT;
                    frame_next  = '0;
                    status_next = ST_OK;
                    entry_next  = '0;
                    if (req.action == ACT_MAP && run_len == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_REQ;
                    end
                end
            end
            S_REQ:
            begin
                mem_req.en = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (level_reg != LVL_LEAF)
                begin
                    if (e_valid && e_inside)
                    begin
                        frame_next = e_off[FRAME_W-1:0];
                        level_next = level_reg - 2'd1;
                        state_next = S_REQ;
                    end
                    else if (!map_reg)
                    begin
                        status_next = ST_NOTFOUND;
                        state_next  = S_DONE;
                    end
                    else if (e_valid || frames_out)
                    begin
                        status_next = ST_NOFRAME;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        sweep_next = '0;
                        state_next = S_SWEEP;
                    end
                end
                else if (!map_reg)
                begin
                    entry_next = mem_rdata;
                    state_next = S_DONE;
                end
                else if (e_valid)
                begin
                    status_next = ST_REMAP;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_req    = '{en: 1'b1, we: 1'b1, addr: slot_addr, wdata: leaf};
                    entry_next = leaf;
                    vpn_next   = vpn_reg + 1'b1;
                    ppn_next   = ppn_reg + 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    level_next = LVL_ROOT;
                    frame_next = '0;
                    if (cnt_reg == RUN_W'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_REQ;
                    end
                end
            end
            S_SWEEP:
            begin
                mem_req = '{en: 1'b1, we: 1'b1,
                            addr: {nff_reg[FRAME_W-1:0], sweep_reg}, wdata: '0};
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == IDX_W'(ENTRIES_PER_FRAME - 1))
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                // frame is cleared first: the slot may lie in the new frame
                mem_req    = '{en: 1'b1, we: 1'b1, addr: slot_addr, wdata: link_pte};
                frame_next = nff_reg[FRAME_W-1:0];
                nff_next   = nff_reg + 1'b1;
                level_next = level_reg - 2'd1;
                state_next = S_REQ;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: status_reg, entry: entry_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            nff_reg       <= NFF_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            nff_reg       <= nff_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_reg  <= sweep_next;
        map_reg    <= map_next;
        vpn_reg    <= vpn_next;
        ppn_reg    <= ppn_next;
        perm_reg   <= perm_next;
        cnt_reg    <= cnt_next;
        level_reg  <= level_next;
        frame_reg  <= frame_next;
        status_reg <= status_next;
        entry_reg  <= entry_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/sv39_page_table_map_lookup_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Lookup: the walk reads each table level in turn, a RAM read then a check, and
// then loads the result. Map walks likewise for each page and, for each new table
// frame, first zeroes the frame one entry a cycle over the single RAM port, then
// links it. Items are taken one at a time; the next is accepted while a result
// waits. After reset the store's 32768 entries are cleared one entry a cycle; no
// transaction is accepted until it ends, configuration writes are.
// ----------------------------------------------------------------------------
// sv39_page_table_map_lookup_core
// Sv39 page table store in internal RAM with map and lookup transactions.
// ----------------------------------------------------------------------------
module sv39_page_table_map_lookup_core
    import sv39ptm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire req_t               req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output rsp_t                    rsp
);

    logic [PPN_W-1:0] table_base;
    mem_req_t         mem_req;
    logic [PTE_W-1:0] mem_rdata;

    sv39ptm_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .table_base (table_base)
    );

    sv39ptm_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .table_base (table_base),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    sv39ptm_ram #(
        .WIDTH (PTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

// ----- tb/sv39ptm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39ptm_checker
// Watches the register, request and response ports of the page table core.
// Keeps its own copy of the table store, frame counter and table base, works
// out the response of every accepted request and compares each accepted
// response with the oldest one still due.
// ----------------------------------------------------------------------------
module sv39ptm_checker
    import sv39ptm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               req_valid,
    input  logic               req_stall,
    input  req_t               req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  rsp_t               rsp,
    output int                 fail_count,
    output int                 outstanding
);

    localparam int NONE    = -1;
    localparam int PPN_LSB = 10;
    localparam int V_BIT   = 0;

    logic [PTE_W-1:0] pte_mem [STORE_DEPTH];
    logic [PPN_W-1:0] base_ppn;
    int               free_frame;
    rsp_t             rsp_due [$];

    function automatic logic [PTE_W-1:0] pte_of(input logic [PPN_W-1:0] p,
                                                 input logic [PERM_W-1:0] flags);
        return {{(PTE_W-PPN_W-PPN_LSB){1'b0}}, p, {(PPN_LSB-PERM_W){1'b0}},
                flags | PERM_W'(1)};
    endfunction

    // internal frame named by a table pointer, NONE if it lies outside the store
    function automatic int frame_of(input logic [PTE_W-1:0] e);
        logic [PPN_W-1:0] off;
        off = e[PPN_LSB +: PPN_W] - base_ppn;
        return (off < PPN_W'(TABLE_FRAMES)) ? int'(off) : NONE;
    endfunction

    function automatic int slot_of(input int frame, input logic [VPN_W-1:0] v,
                                   input int level);
        return frame * ENTRIES_PER_FRAME + int'(v[IDX_W*level +: IDX_W]);
    endfunction

    function automatic int leaf_slot(input logic [VPN_W-1:0] v);
        int               frame;
        logic [PTE_W-1:0] e;
        frame = 0;
        for (int level = LVL_ROOT; level > LVL_LEAF; level--)
        begin
            e = pte_mem[slot_of(frame, v, level)];
            if (!e[V_BIT])
                return NONE;
            frame = frame_of(e);
            if (frame == NONE)
                return NONE;
        end
        return slot_of(frame, v, LVL_LEAF);
    endfunction

    // as leaf_slot, but builds missing tables from the free frame counter
    function automatic int leaf_slot_alloc(input logic [VPN_W-1:0] v);
        int               frame;
        int               s;
        int               nf;
        logic [PTE_W-1:0] e;
        frame = 0;
        for (int level = LVL_ROOT; level > LVL_LEAF; level--)
        begin
            s = slot_of(frame, v, level);
            e = pte_mem[s];
            if (e[V_BIT])
            begin
                frame = frame_of(e);
                if (frame == NONE)
                    return NONE;
            end
            else
            begin
                if (free_frame >= TABLE_FRAMES)
                    return NONE;
                nf = free_frame;
                free_frame++;
                for (int i = 0; i < ENTRIES_PER_FRAME; i++)
                    pte_mem[nf*ENTRIES_PER_FRAME + i] = '0;
                pte_mem[s] = pte_of(base_ppn + PPN_W'(nf), '0);
                frame = nf;
            end
        end
        return slot_of(frame, v, LVL_LEAF);
    endfunction

    function automatic rsp_t resolve(input req_t r);
        rsp_t             x;
        int               s;
        int               n;
        logic [VPN_W-1:0] v;
        logic [PPN_W-1:0] p;
        logic [PTE_W-1:0] leaf;
        x.status = ST_OK;
        x.entry  = '0;
        v = r.vpn;
        p = r.ppn;
        if (r.action == ACT_LOOKUP)
        begin
            s = leaf_slot(v);
            if (s == NONE)
                x.status = ST_NOTFOUND;
            else
                x.entry = pte_mem[s];
        end
        else
        begin
            n = (r.page_count > PC_W'(MAX_RUN)) ? MAX_RUN : int'(r.page_count);
            for (int i = 0; i < n; i++)
            begin
                s = leaf_slot_alloc(v);
                if (s == NONE)
                begin
                    x.status = ST_NOFRAME;
                    break;
                end
                if (pte_mem[s][V_BIT])
                begin
                    x.status = ST_REMAP;
                    break;
                end
                leaf = pte_of(p, r.perm);
                pte_mem[s] = leaf;
                x.entry = leaf;
                v = v + 1'b1;
                p = p + 1'b1;
            end
        end
        return x;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                pte_mem[i] = '0;
            base_ppn   = '0;
            free_frame = 1;
            rsp_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response transaction with none due: status %0d entry %h",
                           rsp.status, rsp.entry);
                    fail_count++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.entry !== want.entry)
                    begin
                        $error("entry: expected %h, actual %h", want.entry, rsp.entry);
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr[3] == REG_TABLE_BASE)
                base_ppn = pwdata[PPN_W-1:0];
            if (req_valid && !req_stall)
                rsp_due.push_back(resolve(req));
            outstanding = rsp_due.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Sv39 page table core: a directed set of maps and lookups
// on the corner cases, then random phases under several table base settings
// with random gaps on requests and random stalls on responses. The checker
// beside the core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb
    import sv39ptm_pkg::*;
();

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int GAP_MAX       = 18;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 32;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 255;
    localparam int RECENT_MAX    = 64;

    localparam logic [PPN_W-1:0] PPN_TOP = '1;
    localparam logic [VPN_W-1:0] VPN_TOP = '1;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_t               req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_t               rsp;

    int                 fail_count;
    int                 outstanding;
    int                 cycles    = 0;
    int                 rsp_hold  = 0;
    logic               rsp_seen  = 1'b0;
    bit                 quiet     = 1'b0;
    logic [VPN_W-1:0]   recent [$];

    sv39_page_table_map_lookup_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    sv39ptm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // response side: a fresh stall length after every accepted transaction
    always @(posedge clk)
        rsp_seen <= rsp_valid && !rsp_stall;

    always @(negedge clk)
    begin
        if (rsp_seen)
            rsp_hold = quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (rsp_hold > 0)
        begin
            rsp_stall <= 1'b1;
            rsp_hold = rsp_hold - 1;
        end
        else
            rsp_stall <= 1'b0;
    end

    function automatic req_t build_req(input logic action, input logic [VPN_W-1:0] vpn,
                                       input logic [PPN_W-1:0] ppn,
                                       input logic [PERM_W-1:0] perm,
                                       input logic [PC_W-1:0] page_count);
        req_t r;
        r.action     = action;
        r.vpn        = vpn;
        r.ppn        = ppn;
        r.perm       = perm;
        r.page_count = page_count;
        return r;
    endfunction

    // mostly a handful of root and mid-level slots, so that tables get reused
    function automatic logic [VPN_W-1:0] pick_vpn(input int recent_pct);
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] mid;
        int               k;
        if (recent.size() > 0 && $urandom_range(0, 99) < recent_pct)
            return recent[$urandom_range(0, recent.size() - 1)] +
                   VPN_W'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 4)
            return VPN_W'($urandom);
        k = $urandom_range(0, 99);
        hi = (k < 40) ? IDX_W'(0) : (k < 60) ? IDX_W'(1) : (k < 80) ? IDX_W'(511) :
             (k < 95) ? IDX_W'(2) : IDX_W'($urandom);
        k = $urandom_range(0, 99);
        mid = (k < 30) ? IDX_W'(0) : (k < 50) ? IDX_W'(1) : (k < 65) ? IDX_W'(511) :
              (k < 80) ? IDX_W'(2) : (k < 90) ? IDX_W'(3) : IDX_W'($urandom);
        return {hi, mid, IDX_W'($urandom)};
    endfunction

    function automatic req_t random_req();
        req_t r;
        int   k;
        r.action = ($urandom_range(0, 99) < 55) ? ACT_MAP : ACT_LOOKUP;
        r.vpn    = pick_vpn((r.action == ACT_MAP) ? 30 : 65);
        r.ppn    = PPN_W'({$urandom, $urandom});
        r.perm   = PERM_W'($urandom);
        k = $urandom_range(0, 99);
        if (k < 75)
            r.page_count = PC_W'($urandom_range(1, 8));
        else if (k < 93)
            r.page_count = PC_W'($urandom_range(9, 64));
        else if (k < 96)
            r.page_count = '0;
        else if (k < 98)
            r.page_count = PC_W'($urandom_range(65, 512));
        else
            r.page_count = PC_W'($urandom_range(513, 2047));
        if (r.action == ACT_MAP)
        begin
            recent.push_back(r.vpn);
            if (recent.size() > RECENT_MAX)
                void'(recent.pop_front());
        end
        return r;
    endfunction

    task automatic send(input req_t r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_base(input logic [PPN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TABLE_BASE, 3'b000};
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        logic [PPN_W-1:0] base;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        write_base('0);
        send(build_req(ACT_LOOKUP, '0, '0, '0, 11'd1));
        send(build_req(ACT_MAP, '0, '0, '0, 11'd1));
        send(build_req(ACT_LOOKUP, '0, '0, '0, 11'd1));
        send(build_req(ACT_LOOKUP, 27'd1, '0, '0, 11'd1));
        send(build_req(ACT_MAP, '0, 44'd5, 8'hFF, 11'd1));
        send(build_req(ACT_MAP, 27'd8, 44'd9, 8'h3C, 11'd0));
        send(build_req(ACT_MAP, 27'd2, PPN_TOP - 1'b1, 8'hFE, 11'd3));
        send(build_req(ACT_LOOKUP, 27'd4, '0, '0, 11'd7));
        // wraps past the top of the space into pages already mapped
        send(build_req(ACT_MAP, VPN_TOP - 1'b1, 44'd100, 8'hA5, 11'd4));
        send(build_req(ACT_MAP, 27'd1, 44'd200, 8'h42, 11'd3));
        send(build_req(ACT_MAP, 27'h0001000, 44'h123_4567_89AB, 8'h5A, 11'd2047));
        send(build_req(ACT_LOOKUP, 27'h00013FF, '0, '0, 11'd1));
        send(build_req(ACT_LOOKUP, 27'h0001400, '0, '0, 11'd1));
        send(build_req(ACT_MAP, 27'h2AAAAAA, 44'hAAA_AAAA_AAAA, 8'h55, 11'd1024));
        send(build_req(ACT_LOOKUP, VPN_TOP, PPN_TOP, 8'hFF, 11'h7FF));
        send(build_req(ACT_LOOKUP, 27'h2AAAAAA, '0, '0, 11'd1));
        settle();

        // existing table pointers now resolve to the frame one above the one they named
        write_base(PPN_TOP);
        send(build_req(ACT_LOOKUP, '0, '0, '0, 11'd1));
        send(build_req(ACT_MAP, 27'h10, 44'd77, 8'h0F, 11'd1));
        send(build_req(ACT_MAP, 27'h4C00000, 44'h555_5555_5555, 8'h80, 11'd2));
        send(build_req(ACT_LOOKUP, 27'h4C00001, '0, '0, 11'd1));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                1:       base = PPN_W'({$urandom, $urandom});
                3:       base = PPN_TOP;
                4:       base = PPN_W'(3);
                default: base = '0;
            endcase
            write_base(base);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 31) == 0)
                    quiet = !quiet;
                send(random_req());
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sv39ptm_pkg.sv
hw/rtl/sv39ptm_ram.sv
hw/rtl/sv39ptm_cfg.sv
hw/rtl/sv39ptm_walk.sv
hw/rtl/sv39_page_table_map_lookup_core.sv
tb/sv39ptm_checker.sv
tb/tb.sv
